[rtl/rgbpk_pkg.sv]
// Shared types and constants for the RGB888 pixel format packer.
// No dependencies; imported by every module of the block.
`default_nettype none

package rgbpk_pkg;

	localparam int unsigned RgbW   = 24;
	localparam int unsigned ChanW  = 8;
	localparam int unsigned WordW  = 32;
	localparam int unsigned PosW   = 5;   // bit position 0..31
	localparam int unsigned LenW   = 6;   // run length 0..32
	localparam int unsigned RegIdxW = 2;

	// pixel format codes
	typedef enum logic [1:0] {
		FMT_RGB_RESERVED = 2'd0,
		FMT_BGR_RESERVED = 2'd1,
		FMT_BITMASK      = 2'd2,
		FMT_UNSUPPORTED  = 2'd3
	} pix_fmt_t;

	// configuration register indexes
	typedef enum logic [RegIdxW-1:0] {
		REG_PIXEL_FORMAT = 2'd0,
		REG_RED_MASK     = 2'd1,
		REG_GREEN_MASK   = 2'd2,
		REG_BLUE_MASK    = 2'd3
	} cfg_reg_t;

	// channel mask plus the lowest run of ones: start bit and length
	typedef struct packed {
		logic [WordW-1:0] mask;
		logic [PosW-1:0]  pos;
		logic [LenW-1:0]  len;
	} chan_geom_t;

	localparam pix_fmt_t FmtRst = FMT_BGR_RESERVED;

	localparam chan_geom_t RedGeomRst = '{
		mask: 32'h00FF_0000, pos: 5'd16, len: 6'd8
	};
	localparam chan_geom_t GreenGeomRst = '{
		mask: 32'h0000_FF00, pos: 5'd8, len: 6'd8
	};
	localparam chan_geom_t BlueGeomRst = '{
		mask: 32'h0000_00FF, pos: 5'd0, len: 6'd8
	};

endpackage

`default_nettype wire

[rtl/rgbpk_mask_geom.sv]
// Finds the lowest run of ones in a channel mask: start bit and length.
// Depends on rgbpk_pkg.
`default_nettype none

module rgbpk_mask_geom (
	input  logic [rgbpk_pkg::WordW-1:0] mask,
	output rgbpk_pkg::chan_geom_t       geom
);
	import rgbpk_pkg::*;

	logic [WordW-1:0] low_bit;
	logic [WordW:0]   sum;
	logic [WordW:0]   end_bit;
	logic [PosW-1:0]  pos;
	logic [LenW-1:0]  end_pos;

	// isolate lowest set bit; adding it carries past the run
	assign low_bit = mask & (~mask + {{(WordW-1){1'b0}}, 1'b1});
	assign sum     = {1'b0, mask} + {1'b0, low_bit};
	assign end_bit = sum & ~{1'b0, mask};

	// one-hot to binary encoders
	always_comb begin
		pos = '0;
		for (int i = 0; i < WordW; i++) begin
			if (low_bit[i]) begin
				pos = pos | PosW'(i);
			end
		end
	end

	always_comb begin
		end_pos = '0;
		for (int i = 0; i <= WordW; i++) begin
			if (end_bit[i]) begin
				end_pos = end_pos | LenW'(i);
			end
		end
	end

	// zero mask gives pos 0 and end 0, so length 0
	assign geom.mask = mask;
	assign geom.pos  = pos;
	assign geom.len  = end_pos - {1'b0, pos};

endmodule

`default_nettype wire

[rtl/rgbpk_cfg_regs.sv]
// Configuration registers: pixel format and three channel masks with
// their precomputed run geometry. Depends on rgbpk_pkg, rgbpk_mask_geom.
`default_nettype none

module rgbpk_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rgbpk_pkg::RegIdxW-1:0] cfg_wr_index,
	input  logic [rgbpk_pkg::WordW-1:0]   cfg_wr_data,
	output rgbpk_pkg::pix_fmt_t           fmt,
	output rgbpk_pkg::chan_geom_t         red_geom,
	output rgbpk_pkg::chan_geom_t         green_geom,
	output rgbpk_pkg::chan_geom_t         blue_geom
);
	import rgbpk_pkg::*;

	pix_fmt_t   fmt_q;
	chan_geom_t red_q;
	chan_geom_t green_q;
	chan_geom_t blue_q;
	chan_geom_t wr_geom;

	// geometry of the incoming mask, stored alongside it
	rgbpk_mask_geom u_wr_geom (
		.mask (cfg_wr_data),
		.geom (wr_geom)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FmtRst;
			red_q   <= RedGeomRst;
			green_q <= GreenGeomRst;
			blue_q  <= BlueGeomRst;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_wr_index))
				REG_PIXEL_FORMAT: fmt_q   <= pix_fmt_t'(cfg_wr_data[1:0]);
				REG_RED_MASK:     red_q   <= wr_geom;
				REG_GREEN_MASK:   green_q <= wr_geom;
				REG_BLUE_MASK:    blue_q  <= wr_geom;
				default: ;
			endcase
		end
	end

	assign fmt        = fmt_q;
	assign red_geom   = red_q;
	assign green_geom = green_q;
	assign blue_geom  = blue_q;

endmodule

`default_nettype wire

[rtl/rgbpk_chan_scale.sv]
// Scales one 8-bit channel to its mask run and places it in the word.
// Depends on rgbpk_pkg.
`default_nettype none

module rgbpk_chan_scale (
	input  logic [rgbpk_pkg::ChanW-1:0] value,
	input  rgbpk_pkg::chan_geom_t       geom,
	output logic [rgbpk_pkg::WordW-1:0] field
);
	import rgbpk_pkg::*;

	// len = 8k + r: (2^len - 1)/255 = (0x0101.. with k bytes) << r,
	// remainder 2^r - 1, so value*(2^len-1)/255 splits into
	// (value replicated k times) << r  plus  floor(value*(2^r-1)/255)
	logic [2:0]        k;
	logic [2:0]        r;
	logic [WordW-1:0]  rep;
	logic [WordW-1:0]  whole;
	logic [14:0]       part;
	logic [15:0]       quot;
	logic [WordW-1:0]  scaled;

	assign k = geom.len[5:3];
	assign r = geom.len[2:0];

	// byte replication: no carries since value < 256
	always_comb begin
		rep = '0;
		for (int i = 0; i < WordW / ChanW; i++) begin
			if (3'(i) < k) begin
				rep[i*ChanW +: ChanW] = value;
			end
		end
	end

	assign whole = rep << r;

	// floor(x/255) = (x + 1 + (x >> 8)) >> 8 for x below 255*256
	assign part   = ({7'd0, value} << r) - {7'd0, value};
	assign quot   = {1'b0, part} + 16'd1 + {9'd0, part[14:8]};
	assign scaled = whole + {25'd0, quot[14:8]};

	assign field = (scaled << geom.pos) & geom.mask;

endmodule

`default_nettype wire

[rtl/rgb888_pixel_format_packer_core.sv]
// RGB888 to framebuffer word packer.
// Pipeline: input register, then result register; both hold while the result register is stalled.
// Throughput: one request per cycle while out_stall is low; channel scaling is a single pass of adds and shifts.
// Reset: format BGR-reserved, masks 0x00FF0000 / 0x0000FF00 / 0x000000FF, pipeline empty.
// Depends on rgbpk_pkg, rgbpk_cfg_regs, rgbpk_chan_scale.
`default_nettype none

module rgb888_pixel_format_packer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rgbpk_pkg::RegIdxW-1:0] cfg_wr_index,
	input  logic [rgbpk_pkg::WordW-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rgbpk_pkg::RgbW-1:0]    rgb_color,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [rgbpk_pkg::WordW-1:0]   pixel_word,
	output logic                          format_error
);
	import rgbpk_pkg::*;

	pix_fmt_t          fmt;
	chan_geom_t        red_geom;
	chan_geom_t        green_geom;
	chan_geom_t        blue_geom;

	logic              vld_s1;
	logic [RgbW-1:0]   rgb_s1;
	logic              vld_s2;
	logic [WordW-1:0]  pixel_s2;
	logic              err_s2;

	logic              adv_s2;
	logic [ChanW-1:0]  red;
	logic [ChanW-1:0]  green;
	logic [ChanW-1:0]  blue;
	logic [WordW-1:0]  red_field;
	logic [WordW-1:0]  green_field;
	logic [WordW-1:0]  blue_field;
	logic [WordW-1:0]  word_nxt;
	logic              err_nxt;

	rgbpk_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_index (cfg_wr_index),
		.cfg_wr_data  (cfg_wr_data),
		.fmt          (fmt),
		.red_geom     (red_geom),
		.green_geom   (green_geom),
		.blue_geom    (blue_geom)
	);

	// handshake: result register frees when empty or taken
	assign adv_s2   = !vld_s2 || !out_stall;
	assign in_stall = vld_s1 && !adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rgb_s1 <= rgb_color;
		end
	end

	assign red   = rgb_s1[23:16];
	assign green = rgb_s1[15:8];
	assign blue  = rgb_s1[7:0];

	// bitmask format: one scaler per channel
	rgbpk_chan_scale u_red (
		.value (red),
		.geom  (red_geom),
		.field (red_field)
	);

	rgbpk_chan_scale u_green (
		.value (green),
		.geom  (green_geom),
		.field (green_field)
	);

	rgbpk_chan_scale u_blue (
		.value (blue),
		.geom  (blue_geom),
		.field (blue_field)
	);

	// format select
	always_comb begin
		word_nxt = '0;
		err_nxt  = 1'b0;
		case (fmt)
			FMT_RGB_RESERVED: word_nxt = {8'd0, blue, green, red};
			FMT_BGR_RESERVED: word_nxt = {8'd0, red, green, blue};
			FMT_BITMASK:      word_nxt = red_field | green_field | blue_field;
			default:          err_nxt  = 1'b1;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			pixel_s2 <= word_nxt;
			err_s2   <= err_nxt;
		end
	end

	assign out_valid    = vld_s2;
	assign pixel_word   = pixel_s2;
	assign format_error = err_s2;

endmodule

`default_nettype wire
